@@ src/pacc_pkg.sv @@
// Shared types and constants of the packet Adler-32 checker and cipher.
package pacc_pkg;

  localparam int unsigned ADLER_MOD  = 65521;
  localparam logic [7:0]  CIPHER_KEY = 8'hC3;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_PLAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_CIPHER = 1'd1;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] header_magic;
    logic [31:0] header_sum;
    logic        cipher_request;
    logic [7:0]  data_byte;
    logic        last;
  } req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        magic_ok;
    logic        encrypted;
    logic [31:0] toggled_magic;
    logic [31:0] computed_sum;
    logic        sum_ok;
    logic        report_valid;
  } rsp_t;

  // Classified request, as it waits between the front and the back.
  typedef struct packed {
    logic        op;
    logic [7:0]  data_byte;
    logic [7:0]  out_byte;
    logic        magic_ok;
    logic        encrypted;
    logic [31:0] toggled_magic;
    logic [31:0] header_sum;
    logic        last;
  } cls_t;

endpackage

@@ src/pacc_front.sv @@
// Front end: magic registers, header classification and payload cipher.
module pacc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pacc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pacc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               req_fire,
  input  pacc_pkg::req_t                     req,
  output pacc_pkg::cls_t                     cls
);
  import pacc_pkg::*;

  logic [31:0] magic_plain;
  logic [31:0] magic_cipher;
  logic        cipher_on;
  logic        is_plain;
  logic        is_cipher;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_plain  <= '0;
      magic_cipher <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC_PLAIN:  magic_plain  <= cfg_data;
        REG_MAGIC_CIPHER: magic_cipher <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the cipher request of each accepted header.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_on <= 1'b0;
    end else if (req_fire && req.op == OP_HEADER) begin
      cipher_on <= req.cipher_request;
    end
  end

  assign is_plain  = (req.header_magic == magic_plain);
  assign is_cipher = (req.header_magic == magic_cipher);

  always_comb begin
    cls            = '0;
    cls.op         = req.op;
    cls.data_byte  = req.data_byte;
    cls.header_sum = req.header_sum;
    cls.last       = req.last;
    if (req.op == OP_HEADER) begin
      cls.magic_ok  = is_plain | is_cipher;
      cls.encrypted = is_cipher;
      if (req.cipher_request) begin
        cls.toggled_magic = is_plain ? magic_cipher : magic_plain;
      end else begin
        cls.toggled_magic = req.header_magic;
      end
    end else begin
      cls.out_byte = cipher_on ? (req.data_byte ^ CIPHER_KEY) : req.data_byte;
    end
  end

endmodule

@@ src/pacc_queue.sv @@
// Short queue of classified requests between front and back.
module pacc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pacc_pkg::cls_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pacc_pkg::cls_t rd_data
);
  import pacc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cls_t          store [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

@@ src/pacc_back.sv @@
// Back end: Adler-32 running sums, checksum report and output register.
module pacc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  pacc_pkg::cls_t cls,
  output logic           take,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pacc_pkg::rsp_t rsp
);
  import pacc_pkg::*;

  localparam logic [16:0] MOD17 = 17'(ADLER_MOD);

  logic [15:0] sum_low;
  logic [15:0] sum_high;
  logic [31:0] expected_sum;
  logic [16:0] low_raw;
  logic [15:0] low_next;
  logic [16:0] high_raw;
  logic [15:0] high_next;
  logic [31:0] total;
  rsp_t        rsp_next;

  assign take = avail && (!rsp_valid || rsp_ready);

  // One conditional subtraction keeps each sum below the modulus.
  always_comb begin
    low_raw   = {1'b0, sum_low} + {9'd0, cls.data_byte};
    low_next  = (low_raw >= MOD17) ? 16'(low_raw - MOD17) : low_raw[15:0];
    high_raw  = {1'b0, sum_high} + {1'b0, low_next};
    high_next = (high_raw >= MOD17) ? 16'(high_raw - MOD17) : high_raw[15:0];
  end

  always_comb begin
    rsp_next               = '0;
    rsp_next.out_byte      = cls.out_byte;
    rsp_next.byte_valid    = (cls.op == OP_DATA);
    rsp_next.magic_ok      = cls.magic_ok;
    rsp_next.encrypted     = cls.encrypted;
    rsp_next.toggled_magic = cls.toggled_magic;
    if (cls.op == OP_HEADER) begin
      total = 32'd1;
      rsp_next.sum_ok = (total == cls.header_sum);
    end else begin
      total = {high_next, low_next};
      rsp_next.sum_ok = (total == expected_sum);
    end
    if (cls.last) begin
      rsp_next.computed_sum = total;
      rsp_next.report_valid = 1'b1;
    end else begin
      rsp_next.sum_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_low      <= 16'd1;
      sum_high     <= 16'd0;
      expected_sum <= '0;
    end else if (take) begin
      if (cls.op == OP_HEADER) begin
        sum_low      <= 16'd1;
        sum_high     <= 16'd0;
        expected_sum <= cls.header_sum;
      end else begin
        sum_low  <= low_next;
        sum_high <= high_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

  a_low_below_mod: assert property (@(posedge clk) disable iff (rst)
    {1'b0, sum_low} < MOD17)
    else $error("sum_low reached the modulus");

  a_high_below_mod: assert property (@(posedge clk) disable iff (rst)
    {1'b0, sum_high} < MOD17)
    else $error("sum_high reached the modulus");

endmodule

@@ src/packet_adler32_check_and_cipher.sv @@
// Top level of the packet Adler-32 checker with XOR payload cipher.
//
// Usage: requests enter on req (valid/ready). A header request (op 0)
// carries the packet magic, its stored checksum and a cipher request; a
// data request (op 1) carries one payload byte. Every request yields exactly
// one response on rsp (valid/ready): headers report the magic match and the
// toggled magic, data requests return the byte (XORed with 0xC3 while the
// cipher is on), and a request with last set also reports the Adler-32 sum
// and whether it equals the stored checksum.
// The two magic values are written through cfg_we/cfg_index/cfg_data while
// the block is idle.
// The response passes through the queue and then the output register; the
// receiver can take it once rsp_valid is high.
// Throughput: one request per cycle while the queue has room; the front
// writes the queue and the back drains it in the same cycle.
// Reset clears the magic registers, cipher state, sums (a=1, b=0), the
// queue and the output valid flag. When the receiver stalls, the output
// register holds its response, the queue fills up to QUEUE_DEPTH entries,
// and then req_ready drops until the receiver takes a response.
module packet_adler32_check_and_cipher #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pacc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pacc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  pacc_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output pacc_pkg::rsp_t                  rsp
);
  import pacc_pkg::*;

  cls_t front_cls;
  cls_t head_cls;
  logic req_fire;
  logic q_full;
  logic q_avail;
  logic q_take;

  // Accept a request whenever the queue has room.
  assign req_ready = !q_full;
  assign req_fire  = req_valid && req_ready;

  pacc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_fire  (req_fire),
    .req       (req),
    .cls       (front_cls)
  );

  pacc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_fire),
    .wr_data   (front_cls),
    .full      (q_full),
    .pop       (q_take),
    .not_empty (q_avail),
    .rd_data   (head_cls)
  );

  // Drain the queue head into the output register when it is free.
  pacc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (q_avail),
    .cls       (head_cls),
    .take      (q_take),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ tb/packet_adler32_checker.sv @@
// Response checker for the packet Adler-32 checker and cipher: predicts and compares.
module packet_adler32_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pacc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pacc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  pacc_pkg::req_t                  req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  pacc_pkg::rsp_t                  rsp,
  output int                              outstanding,
  output int                              fail_count
);
  import pacc_pkg::*;

  logic [31:0] magic_plain;
  logic [31:0] magic_cipher;
  logic [15:0] sum_a;
  logic [15:0] sum_b;
  logic [31:0] stored_sum;
  logic        cipher_on;
  rsp_t        awaited_rsp[$];

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // Advance the running sums and header state by one request, give its response.
  task automatic apply_request(input req_t r, output rsp_t want);
    logic [16:0] acc;
    want = '0;
    if (r.op == OP_HEADER) begin
      sum_a      = 16'd1;
      sum_b      = 16'd0;
      stored_sum = r.header_sum;
      cipher_on  = r.cipher_request;
      want.magic_ok  = (r.header_magic == magic_plain) || (r.header_magic == magic_cipher);
      want.encrypted = (r.header_magic == magic_cipher);
      if (r.cipher_request) begin
        want.toggled_magic = (r.header_magic == magic_plain) ? magic_cipher : magic_plain;
      end else begin
        want.toggled_magic = r.header_magic;
      end
    end else begin
      acc = {1'b0, sum_a} + {9'd0, r.data_byte};
      if (acc >= ADLER_MOD) acc = acc - 17'(ADLER_MOD);
      sum_a = acc[15:0];
      acc = {1'b0, sum_b} + {1'b0, sum_a};
      if (acc >= ADLER_MOD) acc = acc - 17'(ADLER_MOD);
      sum_b = acc[15:0];
      want.out_byte   = cipher_on ? (r.data_byte ^ CIPHER_KEY) : r.data_byte;
      want.byte_valid = 1'b1;
    end
    if (r.last) begin
      want.computed_sum = {sum_b, sum_a};
      want.sum_ok       = ({sum_b, sum_a} == stored_sum);
      want.report_valid = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      magic_plain  = '0;
      magic_cipher = '0;
      sum_a        = 16'd1;
      sum_b        = 16'd0;
      stored_sum   = '0;
      cipher_on    = 1'b0;
      awaited_rsp.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAGIC_PLAIN) begin
          magic_plain = cfg_data;
        end else if (cfg_index == REG_MAGIC_CIPHER) begin
          magic_cipher = cfg_data;
        end
      end
      // Compare first: a request taken at this edge cannot answer at this edge.
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("unexpected response %h", rsp));
        end else begin
          want = awaited_rsp.pop_front();
          check_field("out_byte", 32'(rsp.out_byte), 32'(want.out_byte));
          check_field("byte_valid", 32'(rsp.byte_valid), 32'(want.byte_valid));
          check_field("magic_ok", 32'(rsp.magic_ok), 32'(want.magic_ok));
          check_field("encrypted", 32'(rsp.encrypted), 32'(want.encrypted));
          check_field("toggled_magic", rsp.toggled_magic, want.toggled_magic);
          check_field("computed_sum", rsp.computed_sum, want.computed_sum);
          check_field("sum_ok", 32'(rsp.sum_ok), 32'(want.sum_ok));
          check_field("report_valid", 32'(rsp.report_valid), 32'(want.report_valid));
        end
      end
      if (req_valid && req_ready) begin
        apply_request(req, want);
        awaited_rsp.push_back(want);
      end
    end
    outstanding = awaited_rsp.size();
  end

endmodule

@@ tb/packet_adler32_check_and_cipher_tb.sv @@
// Testbench top for the packet Adler-32 checker and cipher: stimulus and verdict.
module packet_adler32_check_and_cipher_tb;
  import pacc_pkg::*;

  // Generous bound: every request waiting out the longest sender gap and
  // receiver stall several times over.
  localparam int CYCLE_LIMIT = 600000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic                  req_ready;
  req_t                  req_item;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp_item;

  int          outstanding;
  int          fail_count;
  int          cycles;
  int          items_sent;
  int          send_stretch;
  int          recv_stretch;
  int          long_left;
  logic [31:0] cur_plain;
  logic [31:0] cur_cipher;
  logic [7:0]  payload_q[$];

  packet_adler32_check_and_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_item)
  );

  packet_adler32_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req_item),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp_item),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Draw an idle count; now and then run a stretch with no idling at all.
  task automatic draw_gap(inout int stretch, output int gap);
    if (stretch > 0) begin
      stretch--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      stretch = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
    end
  endtask

  // Fill every field at random, so that the unused ones toggle as well.
  function automatic req_t random_request();
    req_t r;
    r.op             = 1'($urandom_range(0, 1));
    r.header_magic   = $urandom;
    r.header_sum     = $urandom;
    r.cipher_request = 1'($urandom_range(0, 1));
    r.data_byte      = 8'($urandom);
    r.last           = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t make_header(input logic [31:0] magic, input logic [31:0] sum,
                                       input logic creq, input logic last);
    req_t r;
    r = random_request();
    r.op             = OP_HEADER;
    r.header_magic   = magic;
    r.header_sum     = sum;
    r.cipher_request = creq;
    r.last           = last;
    return r;
  endfunction

  function automatic req_t make_data(input logic [7:0] value, input logic last);
    req_t r;
    r = random_request();
    r.op        = OP_DATA;
    r.data_byte = value;
    r.last      = last;
    return r;
  endfunction

  // Checksum of the staged payload, used to build headers that should pass.
  function automatic logic [31:0] payload_adler();
    int unsigned a;
    int unsigned b;
    a = 1;
    b = 0;
    foreach (payload_q[i]) begin
      a = (a + payload_q[i]) % ADLER_MOD;
      b = (b + a) % ADLER_MOD;
    end
    return {b[15:0], a[15:0]};
  endfunction

  // Hold off for the drawn gap, then present the request and hold it until taken.
  task automatic send_request(input req_t r);
    int gap;
    draw_gap(send_stretch, gap);
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_item  <= r;
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted response has come back.
  task automatic drain_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Write both magic registers; the block is idle here.
  task automatic write_magics(input logic [31:0] plain, input logic [31:0] cipher);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAGIC_PLAIN;
    cfg_data  <= plain;
    @(negedge clk);
    cfg_index <= REG_MAGIC_CIPHER;
    cfg_data  <= cipher;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_plain  = plain;
    cur_cipher = cipher;
  endtask

  // Header followed by its payload; a bad sum flips one bit or is random.
  task automatic send_packet(input logic [31:0] magic, input logic creq, input int len,
                             input logic ff_fill, input logic good_sum);
    logic [31:0] sum;
    int i;
    payload_q.delete();
    for (i = 0; i < len; i++) begin
      payload_q.push_back(ff_fill ? 8'hFF : 8'($urandom));
    end
    sum = payload_adler();
    if (!good_sum) begin
      sum = $urandom_range(0, 1) ? (sum ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
    end
    send_request(make_header(magic, sum, creq, len == 0));
    for (i = 0; i < len; i++) begin
      send_request(make_data(payload_q[i], i == len - 1));
    end
  endtask

  // Pick a magic word: mostly the configured ones, otherwise an outlier.
  function automatic logic [31:0] pick_magic();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return cur_plain;
    if (roll < 7) return cur_cipher;
    if (roll == 7) return 32'h0000_0000;
    if (roll == 8) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Well-formed packets with random content, plus noise requests.
  task automatic random_phase(input int target);
    int roll;
    int len;
    while (items_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        repeat ($urandom_range(1, 4)) send_request(random_request());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          len = $urandom_range(0, 12);
        end else if (roll < 97 || long_left == 0) begin
          len = $urandom_range(13, 60);
        end else begin
          len = $urandom_range(257, 400);
          long_left--;
        end
        send_packet(pick_magic(), 1'($urandom_range(0, 1)), len,
                    len > 256 && $urandom_range(0, 1) == 1, $urandom_range(0, 9) < 7);
      end
      // Pause now and then until the block has answered everything.
      if ($urandom_range(0, 39) == 0) drain_responses();
    end
  endtask

  // Draw a stall per response; ready never waits for valid.
  initial begin
    int gap;
    rsp_ready    = 1'b0;
    recv_stretch = 0;
    forever begin
      draw_gap(recv_stretch, gap);
      repeat (gap) begin
        @(negedge clk);
        rsp_ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
    end
  end

  initial begin
    rst          = 1'b1;
    cycles       = 0;
    cfg_we       = 1'b0;
    cfg_index    = REG_MAGIC_PLAIN;
    cfg_data     = '0;
    req_valid    = 1'b0;
    req_item     = '0;
    items_sent   = 0;
    send_stretch = 0;
    long_left    = 2;
    cur_plain    = '0;
    cur_cipher   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset magics are both zero: data before any header, then equal registers.
    send_request(make_data(8'hFF, 1'b0));
    send_request(make_data(8'h00, 1'b1));
    send_request(make_header(32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1));
    send_request(make_header(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1));
    drain_responses();

    write_magics(32'hFFFF_FFFF, 32'h0000_0000);
    // Payload FF, 00 sums to a = 0x100, b = 0x200.
    send_request(make_header(32'hFFFF_FFFF, 32'h0200_0100, 1'b1, 1'b0));
    send_request(make_data(8'hFF, 1'b0));
    send_request(make_data(8'h00, 1'b1));
    // Encrypted magic, empty payload against a wrong stored sum.
    send_request(make_header(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1));
    // Unknown magic, without and with the cipher.
    send_request(make_header(32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0));
    send_request(make_data(8'h5A, 1'b1));
    send_request(make_header(32'h1234_5678, 32'h0000_0001, 1'b1, 1'b1));
    // Keep accumulating past a last with no new header.
    send_request(make_data(8'hA5, 1'b1));
    send_request(make_data(8'h00, 1'b0));
    send_request(make_data(8'hFF, 1'b1));
    drain_responses();

    write_magics($urandom, $urandom);
    random_phase(items_sent + 320);
    drain_responses();

    write_magics(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Long all-ones payload drives both sums across the modulus.
    send_packet(cur_plain, 1'b1, 300, 1'b1, 1'b1);
    random_phase(items_sent + 320);
    drain_responses();

    write_magics(32'h0000_0000, 32'hFFFF_FFFF);
    random_phase(items_sent + 290);
    drain_responses();

    write_magics($urandom, $urandom);
    random_phase(items_sent + 290);
    drain_responses();

    // Let stray responses show up before the verdict.
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
